[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the block pool allocator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fbfl_pkg.sv]
// Package for the fixed block free list allocator: sizes, status codes
// and the controller/datapath interface structs. No dependencies.
package fbfl_pkg;

    // Block size must be a power of two; offsets are split by bit slicing.
    localparam int BLOCK_COUNT = 32;
    localparam int BLOCK_BYTES = 64;

    localparam int IDX_W    = $clog2(BLOCK_COUNT);
    localparam int LINK_W   = $clog2(BLOCK_COUNT + 1);
    localparam int BB_SHIFT = $clog2(BLOCK_BYTES);
    localparam int ADDR_W   = 32;
    localparam int STAT_W   = 3;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(BLOCK_COUNT);
    localparam logic [ADDR_W-1:0] POOL_SPAN = ADDR_W'(BLOCK_COUNT * BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'd4096;

    localparam logic [0:0] FUNC_ALLOC = 1'b0;
    localparam logic [0:0] FUNC_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_ALLOC  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FREED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NULL   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_DOUBLE = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input beat
        logic eval;   // classify the request, push on a good free
        logic pop;    // finish an allocate with the fetched link
        logic emit;   // move the result into the output register
    } fbfl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic need_pop;  // allocate with a non-empty list
        logic out_busy;  // output register holds a beat not yet taken
    } fbfl_sts_t;

endpackage

[sv/fixed_block_free_list_allocator.sv]
// Fixed-size block pool allocator, top level: joins the controller and the
// datapath. Depends on fbfl_pkg, fbfl_ctrl, fbfl_dpath and assert_macros.svh.
//
// This block hands out and takes back equal blocks of a pool of 32 blocks of 64
// bytes, starting at the byte address in pool_base (4096 after reset). Free
// blocks sit on a last-in first-out list; after reset it holds every block in
// ascending order. Each request beat gives exactly one result beat. An allocate
// returns the head block's address with status allocated, or status pool empty
// and address zero. A free of a null address, of an address outside the pool or
// not on a block boundary, or of a block that is already free is ignored and
// reported by its own status code; a good free puts the block back at the head.
// Requests are worked one at a time. A free steps through the idle state, in
// which the request beat is accepted, then check and done; an allocate steps
// through idle, check, pop and done, the pop state using the registered read
// of the link memory. The result is moved into the output register as the
// done state is left. The next request is taken in the cycle that follows,
// even if the sink has not yet taken the result. A new result waits while the
// output register still holds a beat the sink has not taken.
// pool_base may be rewritten while the block is idle; the list keeps block
// indices, so later addresses follow the new base.
`include "assert_macros.svh"

module fixed_block_free_list_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: pool_base write.
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] block_addr
    input  logic        s_tuser,   // [0] func
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_addr
    output logic [2:0]  m_tuser    // [2:0] status
);

    fbfl_pkg::fbfl_cmd_t cmd;
    fbfl_pkg::fbfl_sts_t sts;

    // The controller steps each request through capture, check, optional
    // link fetch and hand-off to the output register.
    fbfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds all list state and the result register.
    fbfl_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    // One request at a time: the cycle after an accepted beat is never ready.
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // Every result carries one of the defined status codes.
    `ASSERT_IMPLY(a_status_legal, aclk, aresetn, m_tvalid, m_tuser <= fbfl_pkg::STAT_DOUBLE, "undefined status code")

    // Only an allocation carries a nonzero address.
    `ASSERT_IMPLY(a_addr_zero, aclk, aresetn, m_tvalid && (m_tuser != fbfl_pkg::STAT_ALLOC), m_tdata == 32'd0, "address on non-allocate result")

endmodule

[sv/fbfl_ctrl.sv]
// Sequencing state machine of the block pool allocator.
// Depends on fbfl_pkg for the command and status structs.
module fbfl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fbfl_pkg::fbfl_sts_t sts,
    output fbfl_pkg::fbfl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_POP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.eval   = 1'b1;
                state_next = sts.need_pop ? S_POP : S_DONE;
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/fbfl_dpath.sv]
// Datapath of the block pool allocator: base register, free list head,
// link memory, free bits and output register. Depends on fbfl_pkg.
module fbfl_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [fbfl_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic [fbfl_pkg::ADDR_W-1:0]    s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fbfl_pkg::ADDR_W-1:0]    m_tdata,
    output logic [fbfl_pkg::STAT_W-1:0]    m_tuser,
    input  fbfl_pkg::fbfl_cmd_t            cmd,
    output fbfl_pkg::fbfl_sts_t            sts
);

    localparam int IDX_W  = fbfl_pkg::IDX_W;
    localparam int LINK_W = fbfl_pkg::LINK_W;
    localparam int ADDR_W = fbfl_pkg::ADDR_W;
    localparam int STAT_W = fbfl_pkg::STAT_W;
    localparam int NBLK   = fbfl_pkg::BLOCK_COUNT;

    logic [ADDR_W-1:0] pool_base_reg;
    logic [LINK_W-1:0] head_reg;
    logic [NBLK-1:0]   free_bits_reg;
    logic [NBLK-1:0]   link_valid_reg;
    logic [LINK_W-1:0] link_mem [NBLK];
    logic [LINK_W-1:0] link_q_reg;

    logic              func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [STAT_W-1:0] status_reg;
    logic [ADDR_W-1:0] raddr_reg;

    logic              m_tvalid_reg;
    logic [ADDR_W-1:0] m_tdata_reg;
    logic [STAT_W-1:0] m_tuser_reg;

    logic [IDX_W-1:0]  head_idx;
    logic              head_null;
    logic [ADDR_W-1:0] offset;
    logic              in_range;
    logic [IDX_W-1:0]  free_idx;
    logic              is_null;
    logic              free_ok;
    logic [STAT_W-1:0] eval_status;
    logic [ADDR_W-1:0] alloc_addr;
    logic [LINK_W-1:0] pop_link;

    assign head_idx  = head_reg[IDX_W-1:0];
    assign head_null = (head_reg == fbfl_pkg::LINK_NULL);

    // Offset from the base, wrapping at 32 bits; a block must start on a boundary.
    assign offset   = addr_reg - pool_base_reg;
    assign in_range = (offset < fbfl_pkg::POOL_SPAN)
                    && (offset[fbfl_pkg::BB_SHIFT-1:0] == '0);
    assign free_idx = offset[fbfl_pkg::BB_SHIFT +: IDX_W];
    assign is_null  = (addr_reg == '0);
    assign free_ok  = (func_reg == fbfl_pkg::FUNC_FREE) && !is_null && in_range
                    && !free_bits_reg[free_idx];

    assign alloc_addr = pool_base_reg + (ADDR_W'(head_idx) << fbfl_pkg::BB_SHIFT);

    always_comb begin
        if (func_reg == fbfl_pkg::FUNC_ALLOC) begin
            eval_status = head_null ? fbfl_pkg::STAT_EMPTY : fbfl_pkg::STAT_ALLOC;
        end else if (is_null) begin
            eval_status = fbfl_pkg::STAT_NULL;
        end else if (!in_range) begin
            eval_status = fbfl_pkg::STAT_RANGE;
        end else if (free_bits_reg[free_idx]) begin
            eval_status = fbfl_pkg::STAT_DOUBLE;
        end else begin
            eval_status = fbfl_pkg::STAT_FREED;
        end
    end

    // A link entry never written since reset stands for its reset successor.
    assign pop_link = link_valid_reg[head_idx] ? link_q_reg : (head_reg + LINK_W'(1));

    assign sts.need_pop = (func_reg == fbfl_pkg::FUNC_ALLOC) && !head_null;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    // Link memory: one write port for pushes, one registered read for pops.
    always_ff @(posedge aclk) begin
        if (cmd.eval && free_ok) begin
            link_mem[free_idx] <= head_reg;
        end
        if (cmd.eval && (func_reg == fbfl_pkg::FUNC_ALLOC)) begin
            link_q_reg <= link_mem[head_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg  <= fbfl_pkg::POOL_BASE_RESET;
            head_reg       <= '0;
            free_bits_reg  <= '1;
            link_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                pool_base_reg <= cfg_wdata;
            end
            if (cmd.eval && free_ok) begin
                head_reg                 <= LINK_W'(free_idx);
                free_bits_reg[free_idx]  <= 1'b1;
                link_valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.pop) begin
                head_reg                <= pop_link;
                free_bits_reg[head_idx] <= 1'b0;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_tuser;
            addr_reg <= s_tdata;
        end
        if (cmd.eval) begin
            status_reg <= eval_status;
            raddr_reg  <= sts.need_pop ? alloc_addr : '0;
        end
        if (cmd.emit) begin
            m_tdata_reg <= raddr_reg;
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
